FILE: rtl/ppu_sar_pkg.sv
package ppu_sar_pkg;

    // Request codes
    localparam logic [3:0] REQ_BUS_READ    = 4'd0;
    localparam logic [3:0] REQ_BUS_WRITE   = 4'd1;
    localparam logic [3:0] REQ_PEEK        = 4'd2;
    localparam logic [3:0] REQ_VBLANK_SET  = 4'd3;
    localparam logic [3:0] REQ_VBLANK_CLR  = 4'd4;
    localparam logic [3:0] REQ_INC_X       = 4'd5;
    localparam logic [3:0] REQ_INC_Y       = 4'd6;
    localparam logic [3:0] REQ_XFER_X      = 4'd7;
    localparam logic [3:0] REQ_XFER_Y      = 4'd8;

    // Register indexes
    localparam logic [2:0] REG_CONTROL = 3'd0;
    localparam logic [2:0] REG_MASK    = 3'd1;
    localparam logic [2:0] REG_STATUS  = 3'd2;
    localparam logic [2:0] REG_SCROLL  = 3'd5;
    localparam logic [2:0] REG_ADDRESS = 3'd6;
    localparam logic [2:0] REG_DATA    = 3'd7;

    localparam logic [13:0] PALETTE_BASE  = 14'h3F00;
    localparam logic [4:0]  COARSE_LAST   = 5'd31;
    localparam logic [4:0]  COARSE_Y_WRAP = 5'd29;
    localparam logic [2:0]  FINE_Y_LAST   = 3'd7;

    typedef struct packed {
        logic [3:0] req_type;
        logic [2:0] reg_index;
        logic [7:0] write_data;
        logic [7:0] vram_read_data;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [13:0] access_addr;
        logic        vram_write;
        logic        vram_fetch;
        logic [15:0] scroll_addr;
        logic [2:0]  fine_x_out;
        logic        nmi;
    } t_out_item;

endpackage

FILE: rtl/ppu_sar_in_stage.sv
module ppu_sar_in_stage (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  ppu_sar_pkg::t_in_item i_in_item,
    output logic                  o_in_stall,
    input  logic                  i_fire,
    output logic                  o_valid,
    output ppu_sar_pkg::t_in_item o_item
);

    logic                  r_valid;
    logic                  n_valid;
    ppu_sar_pkg::t_in_item r_item;
    logic                  take;

    assign o_in_stall = r_valid && !i_fire;
    assign take       = i_in_valid && !o_in_stall;
    assign n_valid    = take || (r_valid && !i_fire);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload needs no reset
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= i_in_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

FILE: rtl/ppu_sar_core.sv
module ppu_sar_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_fire,
    input  ppu_sar_pkg::t_in_item  i_item,
    output ppu_sar_pkg::t_out_item o_result
);

    logic [7:0]  r_ctrl,   n_ctrl;
    logic [7:0]  r_mask,   n_mask;
    logic        r_vblank, n_vblank;
    logic        r_toggle, n_toggle;
    logic [2:0]  r_fine_x, n_fine_x;
    logic [15:0] r_tmp,    n_tmp;
    logic [15:0] r_cur,    n_cur;
    logic [7:0]  r_buf,    n_buf;

    logic [13:0] acc;
    logic [15:0] inc;
    logic        rendering;
    logic [7:0]  rd;
    logic        vw;
    logic        vf;
    logic        nmi;
    logic [4:0]  cy;
    logic [7:0]  wd;

    assign acc       = r_cur[13:0];
    assign inc       = r_ctrl[2] ? 16'd32 : 16'd1;
    assign rendering = r_mask[3] || r_mask[4];
    assign cy        = r_cur[9:5];
    assign wd        = i_item.write_data;

    always_comb begin
        n_ctrl   = r_ctrl;
        n_mask   = r_mask;
        n_vblank = r_vblank;
        n_toggle = r_toggle;
        n_fine_x = r_fine_x;
        n_tmp    = r_tmp;
        n_cur    = r_cur;
        n_buf    = r_buf;
        rd       = 8'd0;
        vw       = 1'b0;
        vf       = 1'b0;
        nmi      = 1'b0;
        unique case (i_item.req_type)
            ppu_sar_pkg::REQ_BUS_READ: begin
                if (i_item.reg_index == ppu_sar_pkg::REG_STATUS) begin
                    rd       = {r_vblank, 2'b00, r_buf[4:0]};
                    n_vblank = 1'b0;
                    n_toggle = 1'b0;
                end else if (i_item.reg_index == ppu_sar_pkg::REG_DATA) begin
                    // palette range skips the read buffer delay
                    rd    = (acc >= ppu_sar_pkg::PALETTE_BASE) ? i_item.vram_read_data
                                                               : r_buf;
                    n_buf = i_item.vram_read_data;
                    vf    = 1'b1;
                    n_cur = r_cur + inc;
                end
            end
            ppu_sar_pkg::REQ_BUS_WRITE: begin
                if (i_item.reg_index == ppu_sar_pkg::REG_CONTROL) begin
                    n_ctrl        = wd;
                    n_tmp[11:10]  = wd[1:0];
                end else if (i_item.reg_index == ppu_sar_pkg::REG_MASK) begin
                    n_mask = wd;
                end else if (i_item.reg_index == ppu_sar_pkg::REG_SCROLL) begin
                    if (!r_toggle) begin
                        n_fine_x   = wd[2:0];
                        n_tmp[4:0] = wd[7:3];
                        n_toggle   = 1'b1;
                    end else begin
                        n_tmp[14:12] = wd[2:0];
                        n_tmp[9:5]   = wd[7:3];
                        n_toggle     = 1'b0;
                    end
                end else if (i_item.reg_index == ppu_sar_pkg::REG_ADDRESS) begin
                    if (!r_toggle) begin
                        n_tmp    = {2'b00, wd[5:0], r_tmp[7:0]};
                        n_toggle = 1'b1;
                    end else begin
                        n_tmp    = {r_tmp[15:8], wd};
                        n_cur    = {r_tmp[15:8], wd};
                        n_toggle = 1'b0;
                    end
                end else if (i_item.reg_index == ppu_sar_pkg::REG_DATA) begin
                    vw    = 1'b1;
                    n_cur = r_cur + inc;
                end
            end
            ppu_sar_pkg::REQ_PEEK: begin
                if (i_item.reg_index == ppu_sar_pkg::REG_CONTROL) begin
                    rd = r_ctrl;
                end else if (i_item.reg_index == ppu_sar_pkg::REG_MASK) begin
                    rd = r_mask;
                end else if (i_item.reg_index == ppu_sar_pkg::REG_STATUS) begin
                    rd = {r_vblank, 7'd0};
                end
            end
            ppu_sar_pkg::REQ_VBLANK_SET: begin
                n_vblank = 1'b1;
                nmi      = r_ctrl[7];
            end
            ppu_sar_pkg::REQ_VBLANK_CLR: begin
                n_vblank = 1'b0;
            end
            ppu_sar_pkg::REQ_INC_X: begin
                if (rendering) begin
                    if (r_cur[4:0] == ppu_sar_pkg::COARSE_LAST) begin
                        // wrap coarse X and flip horizontal nametable
                        n_cur[4:0] = 5'd0;
                        n_cur[10]  = ~r_cur[10];
                    end else begin
                        n_cur = r_cur + 16'd1;
                    end
                end
            end
            ppu_sar_pkg::REQ_INC_Y: begin
                if (rendering) begin
                    if (r_cur[14:12] != ppu_sar_pkg::FINE_Y_LAST) begin
                        n_cur = r_cur + 16'h1000;
                    end else begin
                        n_cur[14:12] = 3'd0;
                        if (cy == ppu_sar_pkg::COARSE_Y_WRAP) begin
                            n_cur[9:5] = 5'd0;
                            n_cur[11]  = ~r_cur[11];
                        end else if (cy == ppu_sar_pkg::COARSE_LAST) begin
                            n_cur[9:5] = 5'd0;
                        end else begin
                            n_cur[9:5] = cy + 5'd1;
                        end
                    end
                end
            end
            ppu_sar_pkg::REQ_XFER_X: begin
                if (rendering) begin
                    n_cur[10]  = r_tmp[10];
                    n_cur[4:0] = r_tmp[4:0];
                end
            end
            ppu_sar_pkg::REQ_XFER_Y: begin
                if (rendering) begin
                    n_cur[14:11] = r_tmp[14:11];
                    n_cur[9:5]   = r_tmp[9:5];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl   <= 8'd0;
            r_mask   <= 8'd0;
            r_vblank <= 1'b0;
            r_toggle <= 1'b0;
            r_fine_x <= 3'd0;
            r_tmp    <= 16'd0;
            r_cur    <= 16'd0;
            r_buf    <= 8'd0;
        end else if (i_fire) begin
            r_ctrl   <= n_ctrl;
            r_mask   <= n_mask;
            r_vblank <= n_vblank;
            r_toggle <= n_toggle;
            r_fine_x <= n_fine_x;
            r_tmp    <= n_tmp;
            r_cur    <= n_cur;
            r_buf    <= n_buf;
        end
    end

    assign o_result.read_data   = rd;
    assign o_result.access_addr = acc;
    assign o_result.vram_write  = vw;
    assign o_result.vram_fetch  = vf;
    assign o_result.scroll_addr = n_cur;
    assign o_result.fine_x_out  = n_fine_x;
    assign o_result.nmi         = nmi;

endmodule

FILE: rtl/ppu_sar_out_stage.sv
module ppu_sar_out_stage (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_load,
    input  ppu_sar_pkg::t_out_item i_result,
    output logic                   o_ready,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output ppu_sar_pkg::t_out_item o_out_item
);

    logic                   r_valid;
    logic                   n_valid;
    ppu_sar_pkg::t_out_item r_item;

    // Free when empty or when the held beat leaves this cycle
    assign o_ready = !r_valid || !i_out_stall;
    assign n_valid = i_load || (r_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_result;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_item  = r_item;

endmodule

FILE: rtl/ppu_scroll_address_registers_top.sv
// Scroll and address register port of the picture processor.
// Input channel: i_in_valid / o_in_stall carry one request beat (bus read or
// write, debug peek, vblank event or render event) in i_in_item.
// Output channel: o_out_valid / i_out_stall carry one result beat per request
// in o_out_item: read byte, access address, memory write and fetch strobes,
// current address and fine X after the request, and NMI.
// The input register feeds the decode and state update, which load the result
// register once that register is free, so a request passes through the input
// register and then the result register before the result beat can be taken.
// Throughput is one request per cycle while the receiver does not stall; the
// control, mask, vblank, latch, fine X, address and read buffer registers
// update in the same cycle the request moves into the result register, so
// each request sees the state left by the one before it.
// Reset (synchronous, active low) clears the state registers and empties both
// stages. When the receiver stalls, the result beat holds; one more request
// waits in the input register, after which o_in_stall rises until the
// result beat is taken.
module ppu_scroll_address_registers_top (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  ppu_sar_pkg::t_in_item  i_in_item,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output ppu_sar_pkg::t_out_item o_out_item
);

    logic                   stage_valid;
    ppu_sar_pkg::t_in_item  stage_item;
    logic                   out_ready;
    logic                   fire;
    ppu_sar_pkg::t_out_item result;

    assign fire = stage_valid && out_ready;

    ppu_sar_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .o_in_stall (o_in_stall),
        .i_fire     (fire),
        .o_valid    (stage_valid),
        .o_item     (stage_item)
    );

    ppu_sar_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (stage_item),
        .o_result (result)
    );

    ppu_sar_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (fire),
        .i_result    (result),
        .o_ready     (out_ready),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

FILE: rtl/ppu_sar_checker.sv
module ppu_sar_checker (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   o_in_stall,
    input ppu_sar_pkg::t_in_item  i_in_item,
    input logic                   o_out_valid,
    input logic                   i_out_stall,
    input ppu_sar_pkg::t_out_item o_out_item
);

    // A stalled result beat stays valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result beat dropped while stalled");

    // Input backpressure only comes from a full, stalled result stage
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output backpressure");

    // A data access is either a write or a fetch
    a_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_item.vram_write && o_out_item.vram_fetch))
        else $error("write and fetch in one result beat");

    // Reset empties the result stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind ppu_scroll_address_registers_top ppu_sar_checker u_checker (.*);

FILE: sim/tb_ppu_scroll_address_registers_top.sv
`timescale 1ns / 1ps

module tb_ppu_scroll_address_registers_top;
    import ppu_sar_pkg::*;

    localparam logic [2:0] REG_UNUSED_3 = 3'd3;
    localparam logic [3:0] REQ_UNKNOWN  = 4'd15;
    localparam int RANDOM_ITEMS = 330;
    localparam int WRAP_WALK    = 40;
    localparam int HOLD_CYCLES  = 80;
    localparam int CYCLE_LIMIT  = 600000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  in_item = '0;
    logic      o_out_valid;
    logic      out_stall = 1'b0;
    t_out_item o_out_item;

    ppu_scroll_address_registers_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (o_out_item)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Shadow copy of the register port state
    logic [7:0]  ctl_reg  = '0;
    logic [7:0]  mask_reg = '0;
    logic        vblank   = 1'b0;
    logic        w_latch  = 1'b0;
    logic [2:0]  fine_x   = '0;
    logic [15:0] t_addr   = '0;
    logic [15:0] v_addr   = '0;
    logic [7:0]  rd_buf   = '0;

    t_out_item pending_results[$];
    int        error_count = 0;
    int        beats_sent = 0;
    int        cycle_count = 0;
    bit        tx_calm = 1'b0;
    logic      rx_calm = 1'b0;
    logic      hold_go = 1'b0;
    bit        hold_done = 1'b0;
    int        hold_left = 0;
    int        run_left = 0;

    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item res;
    } t_dir_row;

    t_dir_row dir_rows[$];

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_out_item scroll_predict(input t_in_item it);
        t_out_item   res;
        logic [13:0] acc;
        logic [4:0]  cy;
        logic        render_on;
        res = '0;
        acc = v_addr[13:0];
        render_on = |mask_reg[4:3];
        res.access_addr = acc;
        case (it.req_type)
            REQ_BUS_READ: begin
                if (it.reg_index == REG_STATUS) begin
                    res.read_data = {vblank, 2'b00, rd_buf[4:0]};
                    vblank = 1'b0;
                    w_latch = 1'b0;
                end else if (it.reg_index == REG_DATA) begin
                    // palette range bypasses the read buffer
                    res.read_data = (acc >= PALETTE_BASE) ? it.vram_read_data : rd_buf;
                    rd_buf = it.vram_read_data;
                    res.vram_fetch = 1'b1;
                    v_addr = v_addr + (ctl_reg[2] ? 16'd32 : 16'd1);
                end
            end
            REQ_BUS_WRITE: begin
                case (it.reg_index)
                    REG_CONTROL: begin
                        ctl_reg = it.write_data;
                        t_addr[11:10] = it.write_data[1:0];
                    end
                    REG_MASK: mask_reg = it.write_data;
                    REG_SCROLL: begin
                        if (!w_latch) begin
                            fine_x = it.write_data[2:0];
                            t_addr[4:0] = it.write_data[7:3];
                        end else begin
                            t_addr[14:12] = it.write_data[2:0];
                            t_addr[9:5] = it.write_data[7:3];
                        end
                        w_latch = ~w_latch;
                    end
                    REG_ADDRESS: begin
                        if (!w_latch) begin
                            t_addr = {2'b00, it.write_data[5:0], t_addr[7:0]};
                        end else begin
                            t_addr[7:0] = it.write_data;
                            v_addr = t_addr;
                        end
                        w_latch = ~w_latch;
                    end
                    REG_DATA: begin
                        res.vram_write = 1'b1;
                        v_addr = v_addr + (ctl_reg[2] ? 16'd32 : 16'd1);
                    end
                    default: ;
                endcase
            end
            REQ_PEEK: begin
                if (it.reg_index == REG_CONTROL) res.read_data = ctl_reg;
                else if (it.reg_index == REG_MASK) res.read_data = mask_reg;
                else if (it.reg_index == REG_STATUS) res.read_data = {vblank, 7'd0};
            end
            REQ_VBLANK_SET: begin
                vblank = 1'b1;
                res.nmi = ctl_reg[7];
            end
            REQ_VBLANK_CLR: vblank = 1'b0;
            REQ_INC_X: begin
                if (render_on) begin
                    if (v_addr[4:0] == COARSE_LAST) begin
                        v_addr[4:0] = '0;
                        v_addr[10] = ~v_addr[10];
                    end else begin
                        v_addr = v_addr + 16'd1;
                    end
                end
            end
            REQ_INC_Y: begin
                if (render_on) begin
                    if (v_addr[14:12] != FINE_Y_LAST) begin
                        v_addr = v_addr + 16'h1000;
                    end else begin
                        cy = v_addr[9:5];
                        v_addr[14:12] = '0;
                        if (cy == COARSE_Y_WRAP) begin
                            v_addr[9:5] = '0;
                            v_addr[11] = ~v_addr[11];
                        end else if (cy == COARSE_LAST) begin
                            v_addr[9:5] = '0;
                        end else begin
                            v_addr[9:5] = cy + 5'd1;
                        end
                    end
                end
            end
            REQ_XFER_X: begin
                if (render_on) begin
                    v_addr[10] = t_addr[10];
                    v_addr[4:0] = t_addr[4:0];
                end
            end
            REQ_XFER_Y: begin
                if (render_on) begin
                    v_addr[14:11] = t_addr[14:11];
                    v_addr[9:5] = t_addr[9:5];
                end
            end
            default: ;
        endcase
        res.scroll_addr = v_addr;
        res.fine_x_out = fine_x;
        return res;
    endfunction

    function automatic void check_result(input t_out_item got);
        t_out_item want;
        if (pending_results.size() == 0) begin
            $error("result beat with nothing expected: %h", got);
            error_count++;
            return;
        end
        want = pending_results.pop_front();
        if (got.read_data !== want.read_data) begin
            $error("read_data: expected %h, got %h", want.read_data, got.read_data);
            error_count++;
        end
        if (got.access_addr !== want.access_addr) begin
            $error("access_addr: expected %h, got %h", want.access_addr, got.access_addr);
            error_count++;
        end
        if (got.vram_write !== want.vram_write) begin
            $error("vram_write: expected %b, got %b", want.vram_write, got.vram_write);
            error_count++;
        end
        if (got.vram_fetch !== want.vram_fetch) begin
            $error("vram_fetch: expected %b, got %b", want.vram_fetch, got.vram_fetch);
            error_count++;
        end
        if (got.scroll_addr !== want.scroll_addr) begin
            $error("scroll_addr: expected %h, got %h", want.scroll_addr, got.scroll_addr);
            error_count++;
        end
        if (got.fine_x_out !== want.fine_x_out) begin
            $error("fine_x_out: expected %h, got %h", want.fine_x_out, got.fine_x_out);
            error_count++;
        end
        if (got.nmi !== want.nmi) begin
            $error("nmi: expected %b, got %b", want.nmi, got.nmi);
            error_count++;
        end
    endfunction

    // Typed rows all run with the current address still at zero
    function automatic void add_row(input logic [3:0] req, input logic [2:0] idx,
                                    input logic [7:0] wd, input logic [7:0] vd,
                                    input bit typed = 1'b0, input logic [7:0] exp_rd = 8'h00,
                                    input logic [2:0] exp_fx = 3'd0, input logic exp_nmi = 1'b0);
        t_dir_row row;
        row.item = '{req_type: req, reg_index: idx, write_data: wd, vram_read_data: vd};
        row.typed = typed;
        row.res = '0;
        row.res.read_data = exp_rd;
        row.res.fine_x_out = exp_fx;
        row.res.nmi = exp_nmi;
        dir_rows.push_back(row);
    endfunction

    task automatic send_beat(input t_in_item item, input bit typed, input t_out_item typed_res);
        int        gap;
        t_out_item model_res;
        gap = tx_calm ? 0 : idle_len();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_item <= item;
        in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        model_res = scroll_predict(item);
        pending_results.push_back(typed ? typed_res : model_res);
        beats_sent++;
    endtask

    task automatic send_op(input logic [3:0] req, input logic [2:0] idx, input logic [7:0] wd);
        t_in_item item;
        item = '{req_type: req, reg_index: idx, write_data: wd,
                 vram_read_data: 8'($urandom)};
        send_beat(item, 1'b0, '0);
    endtask

    // Receiver: random stall runs, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) check_result(o_out_item);
            if (hold_go && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (run_left > 0) begin
                run_left--;
            end else if (rx_calm) begin
                out_stall <= 1'b0;
            end else begin
                out_stall <= ($urandom_range(0, 99) < 30);
                run_left = idle_len();
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        int          start;
        logic [7:0]  wd;
        logic [4:0]  cy;
        logic [2:0]  fy;
        int          r;
        t_in_item    item;

        add_row(REQ_PEEK,       REG_CONTROL,  8'h00, 8'h11, 1'b1);
        add_row(REQ_BUS_READ,   REG_STATUS,   8'h00, 8'h22, 1'b1);
        add_row(REQ_VBLANK_SET, REG_CONTROL,  8'h00, 8'h00, 1'b1);
        add_row(REQ_PEEK,       REG_STATUS,   8'h00, 8'h00, 1'b1, 8'h80);
        add_row(REQ_BUS_WRITE,  REG_CONTROL,  8'hFF, 8'h00, 1'b1);
        add_row(REQ_VBLANK_SET, REG_STATUS,   8'h00, 8'hFF, 1'b1, 8'h00, 3'd0, 1'b1);
        add_row(REQ_BUS_READ,   REG_STATUS,   8'hFF, 8'h00, 1'b1, 8'h80);
        add_row(REQ_BUS_WRITE,  REG_MASK,     8'h18, 8'h00, 1'b1);
        add_row(REQ_BUS_WRITE,  REG_SCROLL,   8'hFF, 8'h00, 1'b1, 8'h00, 3'd7);
        add_row(REQ_BUS_WRITE,  REG_SCROLL,   8'h00, 8'hFF, 1'b1, 8'h00, 3'd7);
        add_row(REQ_BUS_WRITE,  REG_ADDRESS,  8'h3F, 8'h00);
        add_row(REQ_BUS_WRITE,  REG_ADDRESS,  8'h00, 8'h00);
        add_row(REQ_BUS_READ,   REG_DATA,     8'h00, 8'hA5);
        add_row(REQ_BUS_WRITE,  REG_DATA,     8'h5A, 8'h00);
        add_row(REQ_BUS_WRITE,  REG_ADDRESS,  8'h00, 8'h00);
        add_row(REQ_BUS_WRITE,  REG_ADDRESS,  8'h00, 8'h00);
        add_row(REQ_BUS_READ,   REG_DATA,     8'h00, 8'h3C);
        add_row(REQ_INC_X,      REG_CONTROL,  8'h00, 8'h00);
        add_row(REQ_INC_Y,      REG_CONTROL,  8'h00, 8'h00);
        add_row(REQ_XFER_X,     REG_CONTROL,  8'h00, 8'h00);
        add_row(REQ_XFER_Y,     REG_CONTROL,  8'h00, 8'h00);
        add_row(REQ_BUS_WRITE,  REG_MASK,     8'hE7, 8'h00);
        add_row(REQ_INC_X,      REG_DATA,     8'h00, 8'h00);
        add_row(REQ_BUS_WRITE,  REG_UNUSED_3, 8'hFF, 8'hFF);
        add_row(REQ_BUS_READ,   REG_CONTROL,  8'hFF, 8'hFF);
        add_row(REQ_VBLANK_CLR, REG_STATUS,   8'h00, 8'h00);
        add_row(REQ_UNKNOWN,    REG_DATA,     8'hFF, 8'hFF);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) send_beat(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].res);

        // Park the address at 0x7FE0 and step it across bit 15 in steps of 32
        send_op(REQ_BUS_READ,  REG_STATUS,  8'h00);
        send_op(REQ_BUS_WRITE, REG_ADDRESS, 8'h3F);
        send_op(REQ_BUS_WRITE, REG_SCROLL,  8'hFF);
        send_op(REQ_BUS_WRITE, REG_SCROLL,  8'h00);
        send_op(REQ_BUS_WRITE, REG_ADDRESS, 8'hE0);
        send_op(REQ_BUS_WRITE, REG_CONTROL, 8'h04);
        repeat (WRAP_WALK) begin
            tx_calm = ($urandom_range(0, 3) != 0);
            send_op($urandom_range(0, 1) ? REQ_BUS_READ : REQ_BUS_WRITE, REG_DATA,
                    8'($urandom));
        end

        start = beats_sent;
        while (beats_sent - start < RANDOM_ITEMS) begin
            tx_calm = ($urandom_range(0, 9) == 0);
            rx_calm <= ($urandom_range(0, 9) == 0);
            if (!hold_done && beats_sent - start > RANDOM_ITEMS / 2) begin
                // keep offering beats while the receiver holds off
                hold_go <= 1'b1;
                tx_calm = 1'b1;
                repeat (12) send_op($urandom_range(0, 1) ? REQ_BUS_READ : REQ_BUS_WRITE,
                                    REG_DATA, 8'($urandom));
                tx_calm = 1'b0;
            end
            case ($urandom_range(0, 6))
                0: begin
                    send_op(REQ_BUS_READ, REG_STATUS, 8'($urandom));
                    send_op(REQ_BUS_WRITE, REG_ADDRESS,
                            $urandom_range(0, 1) ? 8'h3F : 8'($urandom));
                    send_op(REQ_BUS_WRITE, REG_ADDRESS, 8'($urandom));
                    repeat ($urandom_range(1, 8))
                        send_op($urandom_range(0, 1) ? REQ_BUS_READ : REQ_BUS_WRITE,
                                REG_DATA, 8'($urandom));
                end
                1, 2: begin
                    wd = 8'($urandom);
                    if ($urandom_range(0, 4) != 0) wd = wd | (8'h08 << $urandom_range(0, 1));
                    send_op(REQ_BUS_WRITE, REG_MASK, wd);
                    send_op(REQ_BUS_READ, REG_STATUS, 8'($urandom));
                    send_op(REQ_BUS_WRITE, REG_SCROLL, 8'($urandom));
                    r = $urandom_range(0, 4);
                    cy = (r == 0) ? COARSE_Y_WRAP : (r == 1) ? COARSE_LAST :
                         (r == 2) ? 5'd28 : 5'($urandom);
                    fy = $urandom_range(0, 1) ? FINE_Y_LAST : 3'($urandom);
                    send_op(REQ_BUS_WRITE, REG_SCROLL, {cy, fy});
                    send_op(REQ_XFER_Y, 3'($urandom), 8'($urandom));
                    send_op(REQ_XFER_X, 3'($urandom), 8'($urandom));
                    repeat ($urandom_range(4, 40)) begin
                        r = $urandom_range(0, 99);
                        send_op((r < 70) ? REQ_INC_X : (r < 90) ? REQ_INC_Y :
                                (r < 95) ? REQ_XFER_X : REQ_XFER_Y,
                                3'($urandom), 8'($urandom));
                    end
                end
                3: begin
                    send_op(REQ_VBLANK_SET, 3'($urandom), 8'($urandom));
                    if ($urandom_range(0, 1)) send_op(REQ_BUS_READ, REG_STATUS, 8'($urandom));
                    send_op(REQ_PEEK, REG_STATUS, 8'($urandom));
                    send_op(REQ_VBLANK_CLR, 3'($urandom), 8'($urandom));
                end
                4: send_op(REQ_BUS_WRITE, REG_CONTROL, 8'($urandom));
                5: send_op(REQ_PEEK, 3'($urandom), 8'($urandom));
                default: begin
                    repeat ($urandom_range(1, 4)) begin
                        item = t_in_item'($urandom);
                        send_beat(item, 1'b0, '0);
                    end
                end
            endcase
        end

        tx_calm = 1'b0;
        rx_calm <= 1'b0;
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
